[hdl/ccsr_pkg.sv]
package ccsr_pkg;

    // Default build sizes.
    localparam int DEF_COVER_SIZE     = 128;
    localparam int DEF_MAX_SOURCE_DIM = 512;

    // Fixed field widths of the port beats.
    localparam int CFG_W       = 10;
    localparam int CFG_INDEX_W = 1;
    localparam int LOAD_XY_W   = 9;
    localparam int COLOR_W     = 8;
    localparam int OUT_XY_W    = 7;
    localparam int PIXEL_W     = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 1'b1;

    // Operation codes carried on func.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic clear;
        logic load_write;
        logic map;
        logic clamp;
        logic addr;
        logic read;
    } ccsr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
    } ccsr_status_t;

endpackage

[hdl/ccsr_ctrl.sv]
module ccsr_ctrl
    import ccsr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         func,
    input  ccsr_status_t status,
    output logic         busy,
    output logic         done,
    output ccsr_cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_CLEAR = 8'b0000_0010,
        ST_LOAD  = 8'b0000_0100,
        ST_MAP   = 8'b0000_1000,
        ST_CLAMP = 8'b0001_0000,
        ST_ADDR  = 8'b0010_0000,
        ST_READ  = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // A new beat may enter while idle, while a load writes, or while a result shows.
    assign busy   = !((state_reg == ST_IDLE) || (state_reg == ST_LOAD) ||
                      (state_reg == ST_OUT));
    assign accept = start && !busy;
    assign done   = (state_reg == ST_OUT);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE, ST_LOAD, ST_OUT:
            begin
                if (accept)
                begin
                    state_next = (func == FUNC_LOAD) ? ST_LOAD : ST_MAP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MAP:   state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_ADDR;
            ST_ADDR:  state_next = ST_READ;
            ST_READ:  state_next = ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    // State register; reset starts the clearing pass over the store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath commands.
    always_comb
    begin
        cmd            = '0;
        cmd.capture    = accept;
        cmd.clear      = (state_reg == ST_CLEAR);
        cmd.load_write = (state_reg == ST_LOAD);
        cmd.map        = (state_reg == ST_MAP);
        cmd.clamp      = (state_reg == ST_CLAMP);
        cmd.addr       = (state_reg == ST_ADDR);
        cmd.read       = (state_reg == ST_READ);
    end

endmodule

[hdl/ccsr_datapath.sv]
module ccsr_datapath
    import ccsr_pkg::*;
#(
    parameter int COVER_SIZE     = DEF_COVER_SIZE,
    parameter int MAX_SOURCE_DIM = DEF_MAX_SOURCE_DIM
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ccsr_cmd_t              cmd,
    output ccsr_status_t           status,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic [LOAD_XY_W-1:0]   load_x,
    input  logic [LOAD_XY_W-1:0]   load_y,
    input  logic [COLOR_W-1:0]     red,
    input  logic [COLOR_W-1:0]     green,
    input  logic [COLOR_W-1:0]     blue,
    input  logic [OUT_XY_W-1:0]    out_x,
    input  logic [OUT_XY_W-1:0]    out_y,
    output logic [PIXEL_W-1:0]     pixel
);

    localparam int DIM_W  = $clog2(MAX_SOURCE_DIM + 1);
    localparam int EXT_W  = (DIM_W > CFG_W) ? DIM_W : CFG_W;
    localparam int DEPTH  = MAX_SOURCE_DIM * MAX_SOURCE_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // Scaled coordinate width and the reciprocal of the cover size.
    localparam int NW     = OUT_XY_W + DIM_W;
    localparam int RW     = NW + 2;
    localparam int SH     = NW + $clog2(COVER_SIZE);
    localparam longint unsigned SCALE      = 64'd1 << SH;
    localparam longint unsigned RECIP_WIDE = (SCALE + COVER_SIZE - 1) / COVER_SIZE;
    localparam logic [RW-1:0]   RECIP      = RW'(RECIP_WIDE);

    // Size register clamped to one through the store dimension.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] value);
        logic [EXT_W-1:0] ext;
        logic [DIM_W-1:0] res;
        ext = EXT_W'(value);
        if (ext == '0)
        begin
            res = DIM_W'(1);
        end
        else if (ext > EXT_W'(MAX_SOURCE_DIM))
        begin
            res = DIM_W'(MAX_SOURCE_DIM);
        end
        else
        begin
            res = DIM_W'(ext);
        end
        return res;
    endfunction

    logic [CFG_W-1:0]      width_reg;
    logic [CFG_W-1:0]      height_reg;
    logic [DIM_W-1:0]      w;
    logic [DIM_W-1:0]      h;
    logic [DIM_W-1:0]      crop;
    logic [DIM_W-1:0]      off_x;
    logic [DIM_W-1:0]      off_y;
    logic [ADDR_W-1:0]     clr_reg;
    logic [ADDR_W-1:0]     ld_addr_reg;
    logic                  ld_ok_reg;
    logic [PIXEL_W-1:0]    ld_pix_reg;
    logic [NW-1:0]         nx_reg;
    logic [NW-1:0]         ny_reg;
    logic [DIM_W-1:0]      offx_reg;
    logic [DIM_W-1:0]      offy_reg;
    logic [NW+RW-1:0]      prod_x;
    logic [NW+RW-1:0]      prod_y;
    logic [NW-1:0]         qx_reg;
    logic [NW-1:0]         qy_reg;
    logic [NW:0]           sum_x;
    logic [NW:0]           sum_y;
    logic [DIM_W-1:0]      sx_reg;
    logic [DIM_W-1:0]      sy_reg;
    logic [ADDR_W-1:0]     rd_addr_reg;
    logic [PIXEL_W-1:0]    rd_data_reg;
    logic [PIXEL_W-1:0]    store_mem [DEPTH];
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [PIXEL_W-1:0]    wr_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(1);
            height_reg <= CFG_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SOURCE_WIDTH:  width_reg  <= cfg_data;
                REG_SOURCE_HEIGHT: height_reg <= cfg_data;
                default:           width_reg  <= width_reg;
            endcase
        end
    end

    assign w = eff_dim(width_reg);
    assign h = eff_dim(height_reg);

    // Center crop of the longer axis down to the shorter one.
    always_comb
    begin
        crop  = w;
        off_x = '0;
        off_y = '0;
        if (w > h)
        begin
            crop  = h;
            off_x = (w - h) >> 1;
        end
        else if (h > w)
        begin
            off_y = (h - w) >> 1;
        end
    end

    // Clearing pass counter, one entry per cycle after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_reg <= clr_reg + ADDR_W'(1);
        end
    end

    assign status.clear_last = (clr_reg == ADDR_W'(DEPTH - 1));

    // Capture of an accepted beat: load address and color, fetch scaled coordinates.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ld_addr_reg <= ADDR_W'(load_y) * ADDR_W'(w) + ADDR_W'(load_x);
            ld_ok_reg   <= (EXT_W'(load_x) < EXT_W'(w)) && (EXT_W'(load_y) < EXT_W'(h));
            ld_pix_reg  <= {red[7:3], green[7:2], blue[7:3]};
            nx_reg      <= NW'(out_x) * NW'(crop);
            ny_reg      <= NW'(out_y) * NW'(crop);
            offx_reg    <= off_x;
            offy_reg    <= off_y;
        end
    end

    // Division by the cover size as a multiply by its reciprocal.
    assign prod_x = nx_reg * RECIP;
    assign prod_y = ny_reg * RECIP;

    always_ff @(posedge clk)
    begin
        if (cmd.map)
        begin
            qx_reg <= NW'(prod_x >> SH);
            qy_reg <= NW'(prod_y >> SH);
        end
    end

    // Add the crop offset and clamp to the last column or row.
    assign sum_x = (NW+1)'(offx_reg) + (NW+1)'(qx_reg);
    assign sum_y = (NW+1)'(offy_reg) + (NW+1)'(qy_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.clamp)
        begin
            sx_reg <= (sum_x >= (NW+1)'(w)) ? (w - DIM_W'(1)) : DIM_W'(sum_x);
            sy_reg <= (sum_y >= (NW+1)'(h)) ? (h - DIM_W'(1)) : DIM_W'(sum_y);
        end
    end

    // Row-major read address.
    always_ff @(posedge clk)
    begin
        if (cmd.addr)
        begin
            rd_addr_reg <= ADDR_W'(sy_reg * w + (2*DIM_W)'(sx_reg));
        end
    end

    // Single write port shared by the clearing pass and pixel loads.
    always_comb
    begin
        wr_en   = cmd.clear || (cmd.load_write && ld_ok_reg);
        wr_addr = cmd.clear ? clr_reg : ld_addr_reg;
        wr_data = cmd.clear ? '0 : ld_pix_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            rd_data_reg <= store_mem[rd_addr_reg];
        end
    end

    assign pixel = rd_data_reg;

endmodule

[hdl/center_crop_square_resampler.sv]
// A load beat is captured on accept and written while the next beat may enter.
// A fetch beat runs the capture, map, clamp, address multiply and registered store read
// steps in turn, then shows its pixel with done; no new beat is taken before that.
// The receiver cannot stall: each result shows for exactly one cycle.
// Reset (rst_n, asynchronous, active low) sets both sizes to one and starts a clearing
// pass over all MAX_SOURCE_DIM*MAX_SOURCE_DIM entries (262144 by default) with busy high.
module center_crop_square_resampler
    import ccsr_pkg::*;
#(
    parameter int COVER_SIZE     = DEF_COVER_SIZE,
    parameter int MAX_SOURCE_DIM = DEF_MAX_SOURCE_DIM
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   start,
    output logic                   busy,
    input  logic                   func,
    input  logic [LOAD_XY_W-1:0]   load_x,
    input  logic [LOAD_XY_W-1:0]   load_y,
    input  logic [COLOR_W-1:0]     red,
    input  logic [COLOR_W-1:0]     green,
    input  logic [COLOR_W-1:0]     blue,
    input  logic [OUT_XY_W-1:0]    out_x,
    input  logic [OUT_XY_W-1:0]    out_y,
    output logic                   done,
    output logic [PIXEL_W-1:0]     pixel
);

    ccsr_cmd_t    cmd;
    ccsr_status_t status;

    // Sequencer for the clearing pass, loads and fetches.
    ccsr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .status (status),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd)
    );

    // Size registers, coordinate mapping and the pixel store.
    ccsr_datapath #(
        .COVER_SIZE     (COVER_SIZE),
        .MAX_SOURCE_DIM (MAX_SOURCE_DIM)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .load_x    (load_x),
        .load_y    (load_y),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_x     (out_x),
        .out_y     (out_y),
        .pixel     (pixel)
    );

endmodule

[hdl/ccsr_checker.sv]
module ccsr_checker
    import ccsr_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic func,
    input logic done
);

    logic accept;

    assign accept = start && !busy;

    // A result beat shows while the block can take the next beat.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while busy");

    // Every accepted fetch beat is followed by its result beat.
    a_fetch_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FUNC_FETCH)) |-> ##5 done)
        else $error("fetch result missing");

    // No result beat appears without an accepted fetch beat before it.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept && (func == FUNC_FETCH), 5))
        else $error("result without fetch");

    // A load leaves the block free to take another beat in the next cycle.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FUNC_LOAD)) |=> (!busy && !done))
        else $error("load stalled the block");

endmodule

bind center_crop_square_resampler ccsr_checker u_checker (.*);
